// File: sv/positional_ordered_list_assert.svh
// Assertion macros shared by the list RTL.
// No dependencies; included by the files that check their own logic.
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

// condition holds at every edge outside reset
`define POL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("list check failed");

// consequent holds in the same cycle as the antecedent
`define POL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list check failed");

// consequent holds in the cycle after the antecedent
`define POL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list check failed");

`endif

// File: sv/pol_pkg.sv
// Shared constants, codes and types of the positional ordered list.
// No dependencies; used by every other file of the block but the assertion header.
package pol_pkg;

   localparam int DEPTH     = 16;
   localparam int WORD_BITS = 32;

   localparam int OP_W     = 3;
   localparam int ITEM_W   = 32;
   localparam int PLACE_W  = 5;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int FILL_W   = 5;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > PLACE_W) ? CNT_W : PLACE_W;
   localparam int WIDE_W = (WORD_BITS > ITEM_W) ? WORD_BITS : ITEM_W;

   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_INS_POS  = 3'd2,
      OP_DEL_HEAD = 3'd3,
      OP_DEL_TAIL = 3'd4,
      OP_DEL_POS  = 3'd5,
      OP_READOUT  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } ctrl_state_type;

   typedef logic [WORD_BITS-1:0] word_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic known;
      logic readout;
      logic slot_free;
      logic read_last;
      logic empty;
   } stat_type;

   // keep the low WORD_BITS bits of an input word, zero-extended if wider
   function automatic word_type to_word(input logic [ITEM_W-1:0] item);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(item);
      return wide[WORD_BITS-1:0];
   endfunction

   // sign-extend a stored word and keep the low ITEM_W bits
   function automatic logic [ITEM_W-1:0] from_word(input word_type w);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(signed'(w));
      return wide[ITEM_W-1:0];
   endfunction

endpackage

// File: sv/pol_if.sv
// Request and response channel interfaces of the positional ordered list.
// Depends on pol_pkg for the field widths.
interface pol_req_if import pol_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [ITEM_W-1:0] item_in;
   logic [PLACE_W-1:0]       place;

   modport source (output valid, output operation, output item_in, output place,
                   input ready);
   modport sink   (input valid, input operation, input item_in, input place,
                   output ready);
endinterface

interface pol_rsp_if import pol_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [ITEM_W-1:0] item_out;
   logic [SLOT_W-1:0]        item_slot;
   logic [FILL_W-1:0]        fill;
   logic                     final_flag;

   modport source (output valid, output status, output item_out, output item_slot,
                   output fill, output final_flag, input ready);
   modport sink   (input valid, input status, input item_out, input item_slot,
                   input fill, input final_flag, output ready);
endinterface

// File: sv/pol_datapath.sv
// Datapath of the list: captured request, cell row, count, read index and
// the response register. Depends on pol_pkg, pol_if and the assertion macros.
`include "positional_ordered_list_assert.svh"

module pol_datapath import pol_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [OP_W-1:0]    req_operation,
   input  logic [ITEM_W-1:0]  req_item_in,
   input  logic [PLACE_W-1:0] req_place,
   input  cmd_type            cmd,
   output stat_type           stat,
   pol_rsp_if.source          rsp_ch
);

   logic [OP_W-1:0]    op_ff;
   logic [ITEM_W-1:0]  item_ff;
   logic [PLACE_W-1:0] place_ff;

   word_type cells_ff [DEPTH];
   word_type cells_in [DEPTH];
   word_type up_sh    [DEPTH];
   word_type dn_sh    [DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ITEM_W-1:0]   item_out_ff, item_out_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                final_ff, final_in;

   logic [CMP_W-1:0] pl_eff, cnt_ext;
   logic             full, empty, past_end, bad_pos, read_last, slot_free, load;
   logic             do_ins, do_del;
   logic [IDX_W-1:0] ins_idx, del_idx, idx;
   status_type       upd_status;
   word_type         new_word;

   // position decode: zero counts as the head
   always_comb begin
      pl_eff   = (place_ff == '0) ? CMP_W'(1) : CMP_W'(place_ff);
      cnt_ext  = CMP_W'(count_ff);
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      past_end = ((pl_eff - CMP_W'(1)) > cnt_ext);
      bad_pos  = (pl_eff > cnt_ext);
      new_word = to_word(item_ff);
   end

   always_comb begin
      if ((op_ff == OP_INS_HEAD) || (op_ff != OP_INS_TAIL && op_ff != OP_INS_POS)) begin
         ins_idx = '0;
      end else if (op_ff == OP_INS_TAIL || past_end) begin
         ins_idx = IDX_W'(count_ff);
      end else begin
         ins_idx = IDX_W'(pl_eff - CMP_W'(1));
      end
      if (op_ff == OP_DEL_TAIL) begin
         del_idx = IDX_W'(count_ff - CNT_W'(1));
      end else if (op_ff == OP_DEL_POS) begin
         del_idx = IDX_W'(pl_eff - CMP_W'(1));
      end else begin
         del_idx = '0;
      end
   end

   always_comb begin
      do_ins     = 1'b0;
      do_del     = 1'b0;
      idx        = '0;
      upd_status = ST_OK;
      case (op_ff) inside
         OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
            if (full) begin
               upd_status = ST_FULL;
            end else begin
               do_ins = 1'b1;
               idx    = ins_idx;
            end
         end
         OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
            if (empty) begin
               upd_status = ST_EMPTY;
            end else if (op_ff == OP_DEL_POS && bad_pos) begin
               upd_status = ST_BAD_POS;
            end else begin
               do_del = 1'b1;
               idx    = del_idx;
            end
         end
         default: begin
         end
      endcase
   end

   // neighbor taps for the shift of the whole row
   always_comb begin
      up_sh[0]       = cells_ff[0];
      dn_sh[DEPTH-1] = cells_ff[DEPTH-1];
      for (int i = 1; i < DEPTH; i++) begin
         up_sh[i]   = cells_ff[i-1];
         dn_sh[i-1] = cells_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.update && do_ins) begin
            if (IDX_W'(i) == idx) begin
               cells_in[i] = new_word;
            end else if (IDX_W'(i) > idx) begin
               cells_in[i] = up_sh[i];
            end
         end else if (cmd.update && do_del && IDX_W'(i) >= idx) begin
            cells_in[i] = dn_sh[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.update && do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.update && do_del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign read_last = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.capture) begin
         rd_idx_in = '0;
      end else if (cmd.emit && !empty) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end
   end

   // response register: load on update or emit, drop on transfer
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign load         = cmd.update || cmd.emit;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);

   always_comb begin
      status_in   = status_ff;
      item_out_in = item_out_ff;
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      final_in    = final_ff;
      if (cmd.update) begin
         status_in   = upd_status;
         item_out_in = '0;
         slot_in     = '0;
         fill_in     = FILL_W'(count_in);
         final_in    = 1'b1;
      end else if (cmd.emit) begin
         if (empty) begin
            status_in   = ST_EMPTY;
            item_out_in = '0;
            slot_in     = '0;
            final_in    = 1'b1;
         end else begin
            status_in   = ST_OK;
            item_out_in = from_word(cells_ff[rd_idx_ff]);
            slot_in     = SLOT_W'(rd_idx_ff);
            final_in    = read_last;
         end
         fill_in = FILL_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         item_ff  <= req_item_in;
         place_ff <= req_place;
      end
      cells_ff    <= cells_in;
      status_ff   <= status_in;
      item_out_ff <= item_out_in;
      slot_ff     <= slot_in;
      fill_ff     <= fill_in;
      final_ff    <= final_in;
   end

   assign stat.known     = (op_ff <= OP_READOUT);
   assign stat.readout   = (op_ff == OP_READOUT);
   assign stat.slot_free = slot_free;
   assign stat.read_last = read_last;
   assign stat.empty     = empty;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.item_out   = item_out_ff;
   assign rsp_ch.item_slot  = slot_ff;
   assign rsp_ch.fill       = fill_ff;
   assign rsp_ch.final_flag = final_ff;

   `POL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `POL_ASSERT_NOW(a_no_overwrite, clock, reset, load, slot_free)
   `POL_ASSERT_NOW(a_read_in_range, clock, reset, cmd.emit && !empty, read_last || (CNT_W'(rd_idx_ff) < count_ff))
   `POL_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.update && do_ins, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

// File: sv/pol_ctrl.sv
// Controller of the list: takes a request, then runs the update or the read
// walk, or drops an unknown code. Depends on pol_pkg.
module pol_ctrl import pol_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.known) begin
               // unknown code: drop it without a response
               state_in = S_IDLE;
            end else if (stat.slot_free) begin
               if (stat.readout) begin
                  cmd.emit = 1'b1;
                  if (stat.empty || stat.read_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  cmd.update = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: sv/positional_ordered_list.sv
// Channel   Dir  Handshake     Payload
// req_ch    in   valid/ready   operation, item_in, place
// rsp_ch    out  valid/ready   status, item_out, item_slot, fill, final_flag
//
// An update is the transfer in, then the execute state that shifts the
// whole cell row and loads the response register.
// A read out emits one response per stored word (one when empty), one word
// per cycle unless the response stalls, via the single read port of the row.
// Reset is synchronous and empties the list; cell contents are not cleared.
// A stalled response holds the execute cycle until the register is taken.
module positional_ordered_list import pol_pkg::*; (
   input logic       clock,
   input logic       reset,
   pol_req_if.sink   req_ch,
   pol_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   pol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pol_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_ch.operation),
      .req_item_in   (req_ch.item_in),
      .req_place     (req_ch.place),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ch        (rsp_ch)
   );

endmodule
